### rtl/ipl_pkg.sv
package ipl_pkg;

  // Fixed field widths
  localparam int unsigned PCT_W = 7;
  localparam int unsigned MS_W  = 32;
  localparam int unsigned SEC_W = 16;
  localparam int unsigned THR_W = 27;

  // Arithmetic constants
  localparam logic [9:0]       MS_PER_S     = 10'd1000;
  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_HYST      = 3'd2;
  localparam logic [2:0] REG_LOW_THR   = 3'd3;
  localparam logic [2:0] REG_HIGH_THR  = 3'd4;
  localparam logic [2:0] REG_REDUCED   = 3'd5;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    C_IDLE,
    C_CHECK,
    C_MEDIAN,
    C_HIGH,
    C_DONE
  } ctl_state_t;

  // Median selector states
  typedef enum logic {
    M_IDLE,
    M_SCAN
  } med_state_t;

  // Status returned by the median selector
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] median;
  } med_sts_t;

endpackage

### rtl/ipl_window.sv
module ipl_window import ipl_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PCT_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [PCT_W-1:0] rd_data
);

  logic [PCT_W-1:0] mem [DEPTH];

  // Sample store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/ipl_median.sv
module ipl_median import ipl_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CW-1:0]    count,
  output logic [AW-1:0]    rd_addr,
  input  logic [PCT_W-1:0] rd_data,
  output med_sts_t         sts
);

  med_state_t       state_r, state_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rank_r, rank_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [PCT_W-1:0] prefix_r, prefix_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic             rdv_r, rdv_nxt;
  logic             done_r, done_nxt;
  logic [7:0]       mask8;
  logic             hit;
  logic [CW-1:0]    cnt_sum;

  // Compare unit: does the returned sample match the prefix above the
  // current bit and hold a zero in that bit?
  assign mask8   = 8'hFF << ({1'b0, bit_r} + 4'd1);
  assign hit     = rdv_r && (((rd_data ^ prefix_r) & mask8[PCT_W-1:0]) == '0)
                   && !rd_data[bit_r];
  assign cnt_sum = cnt_r + CW'(hit);

  assign rd_addr    = idx_r[AW-1:0];
  assign sts.done   = done_r;
  assign sts.median = prefix_r;

  // Bitwise rank selection: one pass over the window for each result bit,
  // from the top bit down.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    rank_nxt   = rank_r;
    count_nxt  = count_r;
    prefix_nxt = prefix_r;
    bit_nxt    = bit_r;
    rdv_nxt    = 1'b0;
    done_nxt   = 1'b0;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          count_nxt  = count;
          rank_nxt   = count >> 1;
          prefix_nxt = '0;
          bit_nxt    = 3'(PCT_W - 1);
          idx_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = M_SCAN;
        end
      end
      M_SCAN: begin
        cnt_nxt = cnt_sum;
        if (idx_r < count_r) begin
          rdv_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        // The last sample of the pass is in; settle this bit.
        if (idx_r == count_r && rdv_r) begin
          if (rank_r >= cnt_sum) begin
            prefix_nxt[bit_r] = 1'b1;
            rank_nxt          = rank_r - cnt_sum;
          end
          cnt_nxt = '0;
          idx_nxt = '0;
          if (bit_r == 3'd0) begin
            done_nxt  = 1'b1;
            state_nxt = M_IDLE;
          end else begin
            bit_nxt = bit_r - 3'd1;
          end
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      rdv_r   <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
    rank_r   <= rank_nxt;
    count_r  <= count_nxt;
    prefix_r <= prefix_nxt;
    bit_r    <= bit_nxt;
  end

endmodule

### rtl/idle_power_limit_controller.sv
// Idle power limit controller. Each input request carries the user idle time
// in milliseconds and, when in_tuser is high, one CPU load sample. An item
// passes the check and done states when it brings no sample or the block is
// disabled, and the high-median check too when its sample leaves an odd fill
// count. When its sample leaves an even fill count, the median is first
// recomputed by the median selector, which makes one pass over the window
// memory per result bit with one registered read a cycle. The result waits in
// an output register, so the next request is taken while it is still pending.
// The window needs no clearing after reset: only written entries are read.
module idle_power_limit_controller import ipl_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // idle_ms[31:0], load_percent[38:32], zero pad
  input  logic        in_tuser,   // sample_valid
  // Result request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // limit_event[0], release_event[1], limited[2],
                                  // median_now[9:3], max_percent_cmd[16:10], zero pad
  // Configuration writes
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  // Configuration registers
  logic             enable_r;
  logic [SEC_W-1:0] timeout_r;
  logic [SEC_W-1:0] hyst_r;
  logic [PCT_W-1:0] low_thr_r;
  logic [PCT_W-1:0] high_thr_r;
  logic [PCT_W-1:0] reduced_r;

  ctl_state_t       state_r, state_nxt;
  logic [MS_W-1:0]  idle_ms_r, idle_ms_nxt;
  logic             svalid_r, svalid_nxt;
  logic [PCT_W-1:0] load_r, load_nxt;
  logic             limit_r, limit_nxt;
  logic [PCT_W-1:0] median_r, median_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [AW-1:0]    oldest_r, oldest_nxt;
  logic             lim_ev_r, lim_ev_nxt;
  logic             rel_ev_r, rel_ev_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  logic             full;
  logic [CW-1:0]    fill_new;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             med_start;
  logic [AW-1:0]    rd_addr;
  logic [PCT_W-1:0] rd_data;
  med_sts_t         med_sts;
  logic [SEC_W-1:0] bound;
  logic [THR_W-1:0] apply_ms;
  logic [THR_W-1:0] release_ms;
  logic             idle_over;
  logic             idle_under;
  logic [PCT_W-1:0] max_pct;

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      timeout_r  <= 16'd300;
      hyst_r     <= 16'd10;
      low_thr_r  <= 7'd10;
      high_thr_r <= 7'd50;
      reduced_r  <= 7'd50;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ENABLE:   enable_r   <= cfg_wdata[0];
        REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        REG_HYST:     hyst_r     <= cfg_wdata;
        REG_LOW_THR:  low_thr_r  <= cfg_wdata[PCT_W-1:0];
        REG_HIGH_THR: high_thr_r <= cfg_wdata[PCT_W-1:0];
        REG_REDUCED:  reduced_r  <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Idle tests in milliseconds: whole seconds above the timeout means at
  // least (timeout + 1) * 1000 ms, and below the release bound means fewer
  // than bound * 1000 ms. The bound saturates at zero.
  assign bound      = (timeout_r >= hyst_r) ? (timeout_r - hyst_r) : '0;
  assign apply_ms   = (THR_W'(timeout_r) + THR_W'(1)) * THR_W'(MS_PER_S);
  assign release_ms = THR_W'(bound) * THR_W'(MS_PER_S);
  assign idle_over  = idle_ms_r >= MS_W'(apply_ms);
  assign idle_under = idle_ms_r < MS_W'(release_ms);

  // Window bookkeeping
  assign full     = (fill_r == CW'(WINDOW_DEPTH));
  assign fill_new = full ? fill_r : (fill_r + 1'b1);
  assign wr_addr  = full ? oldest_r : fill_r[AW-1:0];

  assign max_pct = limit_r ? reduced_r : FULL_PERCENT;

  assign in_tready  = (state_r == C_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    idle_ms_nxt   = idle_ms_r;
    svalid_nxt    = svalid_r;
    load_nxt      = load_r;
    limit_nxt     = limit_r;
    median_nxt    = median_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    lim_ev_nxt    = lim_ev_r;
    rel_ev_nxt    = rel_ev_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    med_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      C_IDLE: begin
        if (in_tvalid) begin
          idle_ms_nxt = in_tdata[31:0];
          load_nxt    = in_tdata[38:32];
          svalid_nxt  = in_tuser;
          lim_ev_nxt  = 1'b0;
          rel_ev_nxt  = 1'b0;
          state_nxt   = C_CHECK;
        end
      end
      C_CHECK: begin
        state_nxt = C_DONE;
        if (enable_r) begin
          if (idle_over) begin
            if (!limit_r && median_r < low_thr_r) begin
              limit_nxt  = 1'b1;
              lim_ev_nxt = 1'b1;
            end
          end else if (limit_r && idle_under) begin
            limit_nxt  = 1'b0;
            rel_ev_nxt = 1'b1;
          end
          // Push the sample; once full, overwrite the oldest slot.
          if (svalid_r) begin
            wr_en    = 1'b1;
            fill_nxt = fill_new;
            if (full) begin
              oldest_nxt = (oldest_r == AW'(WINDOW_DEPTH - 1)) ? '0 : (oldest_r + 1'b1);
            end
            if (!fill_new[0]) begin
              med_start = 1'b1;
              state_nxt = C_MEDIAN;
            end else begin
              state_nxt = C_HIGH;
            end
          end
        end
      end
      C_MEDIAN: begin
        if (med_sts.done) begin
          median_nxt = med_sts.median;
          state_nxt  = C_HIGH;
        end
      end
      C_HIGH: begin
        if (limit_r && median_r > high_thr_r) begin
          limit_nxt  = 1'b0;
          rel_ev_nxt = 1'b1;
        end
        state_nxt = C_DONE;
      end
      C_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, max_pct, median_r, limit_r, rel_ev_r, lim_ev_r};
          state_nxt     = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      limit_r     <= 1'b0;
      median_r    <= '0;
      fill_r      <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
      lim_ev_r    <= 1'b0;
      rel_ev_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      median_r    <= median_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
      lim_ev_r    <= lim_ev_nxt;
      rel_ev_r    <= rel_ev_nxt;
    end
    idle_ms_r  <= idle_ms_nxt;
    svalid_r   <= svalid_nxt;
    load_r     <= load_nxt;
    out_data_r <= out_data_nxt;
  end

  ipl_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (load_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ipl_median #(
    .DEPTH (WINDOW_DEPTH)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (med_start),
    .count   (fill_new),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .sts     (med_sts)
  );

endmodule

### test/tb_idle_power_limit_controller.sv
module tb_idle_power_limit_controller;
  import ipl_pkg::*;

  localparam int unsigned WIN_DEPTH   = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned PRINT_CAP   = 40;

  // One result request, laid out as on out_tdata (lowest field last here).
  typedef struct packed {
    logic [6:0]       pad;
    logic [PCT_W-1:0] max_cmd;
    logic [PCT_W-1:0] median;
    logic             limited;
    logic             released;
    logic             applied;
  } status_t;

  // One full set of configuration registers.
  typedef struct {
    bit               on;
    logic [SEC_W-1:0] timeout_s;
    logic [SEC_W-1:0] hyst_s;
    logic [PCT_W-1:0] low_thr;
    logic [PCT_W-1:0] high_thr;
    logic [PCT_W-1:0] reduced_pct;
  } settings_t;

  // Tracks the controller state, predicts each result and checks the ones that arrive.
  class limit_tracker;
    bit               enabled;
    logic [SEC_W-1:0] timeout_s;
    logic [SEC_W-1:0] hyst_s;
    logic [PCT_W-1:0] low_thr;
    logic [PCT_W-1:0] high_thr;
    logic [PCT_W-1:0] reduced_pct;
    bit               limit_on;
    logic [PCT_W-1:0] median;
    logic [PCT_W-1:0] window [WIN_DEPTH];
    int unsigned      fill;
    int unsigned      oldest;
    status_t          expected_status[$];
    int unsigned      errors;
    int unsigned      seen;

    function new();
      enabled     = 1'b0;
      timeout_s   = 16'd300;
      hyst_s      = 16'd10;
      low_thr     = 7'd10;
      high_thr    = 7'd50;
      reduced_pct = 7'd50;
      limit_on    = 1'b0;
      median      = '0;
      fill        = 0;
      oldest      = 0;
      errors      = 0;
      seen        = 0;
    endfunction

    function void write_register(logic [2:0] index, logic [15:0] value);
      case (index)
        REG_ENABLE:   enabled     = value[0];
        REG_TIMEOUT:  timeout_s   = value[SEC_W-1:0];
        REG_HYST:     hyst_s      = value[SEC_W-1:0];
        REG_LOW_THR:  low_thr     = value[PCT_W-1:0];
        REG_HIGH_THR: high_thr    = value[PCT_W-1:0];
        REG_REDUCED:  reduced_pct = value[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    // Upper median of the filled part of the window, by insertion sort.
    function logic [PCT_W-1:0] upper_median();
      logic [PCT_W-1:0] sorted [WIN_DEPTH];
      logic [PCT_W-1:0] v;
      int unsigned      i;
      int unsigned      j;
      for (i = 0; i < fill; i++) begin
        v = window[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[fill / 2];
    endfunction

    // Idle check first, then the load window; queue the status this request yields.
    function void predict_status(logic [MS_W-1:0] idle_ms, bit has_sample,
                                 logic [PCT_W-1:0] load);
      logic [31:0] idle_s;
      logic [31:0] release_below;
      status_t     s;
      idle_s = idle_ms / MS_PER_S;
      s = '0;
      if (enabled) begin
        release_below = (timeout_s >= hyst_s) ? 32'(timeout_s - hyst_s) : 32'd0;
        if (idle_s > 32'(timeout_s)) begin
          if (!limit_on && median < low_thr) begin
            limit_on  = 1'b1;
            s.applied = 1'b1;
          end
        end else if (limit_on && idle_s < release_below) begin
          limit_on   = 1'b0;
          s.released = 1'b1;
        end
        if (has_sample) begin
          if (fill >= WIN_DEPTH) begin
            window[oldest] = load;
            oldest = (oldest + 1) % WIN_DEPTH;
          end else begin
            window[fill] = load;
            fill++;
          end
          if (fill % 2 == 0) median = upper_median();
          if (limit_on && median > high_thr) begin
            limit_on   = 1'b0;
            s.released = 1'b1;
          end
        end
      end
      s.limited = limit_on;
      s.median  = median;
      s.max_cmd = limit_on ? reduced_pct : FULL_PERCENT;
      expected_status = {expected_status, s};
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare_field(string field, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result %0d: %s is %0d, expected %0d", seen, field, got, want));
    endtask

    task check_status(logic [23:0] data);
      status_t got;
      status_t want;
      got = data;
      seen++;
      if (expected_status.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", seen));
        return;
      end
      want = expected_status.pop_front();
      compare_field("limit_event", got.applied, want.applied);
      compare_field("release_event", got.released, want.released);
      compare_field("limited", got.limited, want.limited);
      compare_field("median_now", got.median, want.median);
      compare_field("max_percent_cmd", got.max_cmd, want.max_cmd);
      compare_field("padding", got.pad, want.pad);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // idle_ms[31:0], load_percent[38:32], zero pad
  logic        in_tuser;   // sample_valid
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // limit_event, release_event, limited, median_now,
                           // max_percent_cmd, zero pad
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  limit_tracker tracker = new();
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_req       = 1'b0;
  int unsigned  cycle_count    = 0;

  idle_power_limit_controller #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** idle_power_limit_controller: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted result request is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_status(out_tdata);
  end

  // Offer one input request, with random idle cycles ahead of it, until it is taken.
  task automatic send_request(input logic [MS_W-1:0] idle_ms, input bit has_sample,
                              input logic [PCT_W-1:0] load);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, load, idle_ms};
    in_tuser  <= has_sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.predict_status(idle_ms, has_sample, load);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_register(index, value);
  endtask

  task automatic program_settings(input settings_t s);
    write_reg(REG_ENABLE, {15'd0, s.on});
    write_reg(REG_TIMEOUT, s.timeout_s);
    write_reg(REG_HYST, s.hyst_s);
    write_reg(REG_LOW_THR, {9'd0, s.low_thr});
    write_reg(REG_HIGH_THR, {9'd0, s.high_thr});
    write_reg(REG_REDUCED, {9'd0, s.reduced_pct});
    cfg_wen <= 1'b0;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Random requests: idle times cluster at the apply and release bounds, loads come
  // in low and high bursts so the limit is applied and released again and again.
  task automatic run_random(input int unsigned n_items);
    int unsigned      k;
    int unsigned      r;
    int unsigned      idle_s;
    int unsigned      base;
    int unsigned      release_below;
    bit               low_burst;
    bit               has_sample;
    logic [PCT_W-1:0] load;
    logic [MS_W-1:0]  idle_ms;
    base = 32'(tracker.timeout_s);
    release_below = (tracker.timeout_s >= tracker.hyst_s) ?
                    32'(tracker.timeout_s - tracker.hyst_s) : 32'd0;
    low_burst = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 6) low_burst = !low_burst;
      r = $urandom_range(99);
      if (r < 8) begin
        idle_ms = $urandom();
      end else begin
        if (r < 40) idle_s = base + $urandom_range(4);
        else if (r < 60) idle_s = release_below + $urandom_range(4);
        else idle_s = $urandom_range(2 * base + 12);
        idle_s  = (idle_s >= 2) ? idle_s - 2 : 0;
        idle_ms = idle_s * 1000 + $urandom_range(999);
      end
      r = $urandom_range(99);
      if (r < 15) load = PCT_W'($urandom_range(127));
      else if (low_burst) load = PCT_W'($urandom_range(tracker.low_thr));
      else load = PCT_W'($urandom_range(127, tracker.high_thr));
      has_sample = ($urandom_range(99) < 75);
      send_request(idle_ms, has_sample, load);
    end
  endtask

  // Main sequence: reset, directed cases, then random phases under varied settings.
  initial begin
    settings_t   plan [8];
    int unsigned p;
    int unsigned t;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Still disabled after reset: requests leave the state alone.
    send_request(32'd400000, 1'b1, 7'd0);
    send_request(32'd0, 1'b1, 7'd127);
    drain();

    program_settings('{1'b1, 16'd5, 16'd2, 7'd10, 7'd50, 7'd30});
    send_request(32'd6000, 1'b1, 7'd0);       // apply on idle, odd fill keeps median
    send_request(32'd5999, 1'b0, 7'd0);       // idle equal to timeout: no change
    send_request(32'd2999, 1'b0, 7'd0);       // idle release
    send_request(32'd6000, 1'b1, 7'd127);     // apply and release in one request
    send_request(32'd0, 1'b1, 7'd5);
    send_request(32'd0, 1'b1, 7'd5);
    send_request(32'hFFFF_FFFF, 1'b0, 7'd0);  // largest idle time
    send_request(32'd7000, 1'b1, 7'd100);
    send_request(32'd7000, 1'b1, 7'd100);     // release on high median
    send_request(32'd0, 1'b1, 7'd0);
    send_request(32'd0, 1'b1, 7'd0);          // window now full
    send_request(32'd0, 1'b1, 7'd1);          // oldest sample replaced
    send_request(32'd0, 1'b1, 7'd64);
    drain();

    // Hysteresis above the timeout: idle release can never happen.
    program_settings('{1'b1, 16'd3, 16'd9, 7'd100, 7'd100, 7'd0});
    send_request(32'd4000, 1'b0, 7'd0);
    send_request(32'd0, 1'b0, 7'd0);
    send_request(32'd0, 1'b1, 7'd127);
    send_request(32'd999, 1'b1, 7'd127);
    drain();

    // Largest timeout, zero hysteresis and thresholds.
    program_settings('{1'b1, 16'd65535, 16'd0, 7'd0, 7'd0, 7'd100});
    send_request(32'd65535999, 1'b0, 7'd0);
    send_request(32'd65536000, 1'b1, 7'd0);
    send_request(32'd65534999, 1'b0, 7'd0);
    drain();

    plan[0] = '{1'b1, 16'd0, 16'd0, 7'd100, 7'd100, 7'd0};
    plan[1] = '{1'b1, 16'd65535, 16'd65535, 7'd0, 7'd0, 7'd100};
    plan[2] = '{1'b1, 16'd20, 16'd5, 7'd30, 7'd60, 7'd40};
    plan[3] = '{1'b1, 16'd300, 16'd10, 7'd10, 7'd50, 7'd50};
    plan[4] = '{1'b0, 16'd15, 16'd3, 7'd50, 7'd50, 7'd25};
    plan[5] = '{1'b1, 16'd8, 16'd12, 7'd60, 7'd20, 7'd70};
    plan[6] = '{1'b1, 16'd120, 16'd119, 7'd40, 7'd45, 7'd10};
    t = $urandom_range(200);
    plan[7] = '{1'b1, 16'(t), 16'($urandom_range(t)), 7'($urandom_range(100)),
                7'($urandom_range(100)), 7'($urandom_range(100))};

    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      program_settings(plan[p]);
      // Long result hold-off while requests keep coming, to back up the input.
      if (p == 0) hold_req = 1'b1;
      run_random(plan[p].on ? 215 : 40);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("** idle_power_limit_controller: PASSED **");
    end else begin
      $display("** idle_power_limit_controller: FAILED **");
    end
    $finish;
  end

endmodule

### idle_power_limit_controller.f
rtl/ipl_pkg.sv
rtl/ipl_window.sv
rtl/ipl_median.sv
rtl/idle_power_limit_controller.sv
test/tb_idle_power_limit_controller.sv
